/* rtl/afpl_pkg.sv */
// ----------------------------------------------------------------------------
// afpl_pkg
// Shared widths, constants, command and status types of the arc free path
// length unit.
// ----------------------------------------------------------------------------
package afpl_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SPEED_W     = 16;
    localparam int RAD_W       = 12;
    localparam int CLR_W       = 16;
    localparam int LEN_W       = 24;
    localparam int CFG_IDX_W   = 1;

    // divider: |v| * 1024 / |w|
    localparam int FRAC_SH   = 10;
    localparam int QUO_W     = SPEED_W + FRAC_SH;
    localparam int REM_W     = SPEED_W + 1;
    localparam int DIV_STEPS = QUO_W;

    localparam int CY_W   = QUO_W + 1;
    localparam int DY_W   = CY_W + 1;
    localparam int MAG_W  = DY_W - 1;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int ROOT_W = ROOT_STEPS;
    localparam int DIST_W = ROOT_W + 1;

    localparam int CORD_W     = 48;
    localparam int ANG_W      = 20;
    localparam int ANG_SHIFT  = 16;
    localparam int CORD_STEPS = 16;
    localparam int CORD_IDX_W = 4;
    localparam int LCO_W      = 20;
    localparam int PROD_W     = LCO_W + QUO_W;
    localparam int RND_W      = PROD_W + 1;

    localparam int CNT_W = 5;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [LEN_W-1:0] LEN_MAX     = 24'sd8388607;
    localparam logic signed [LEN_W-1:0] LEN_MIN     = -24'sd8388608;

    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_RADIUS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEARANCE_LIMIT = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_STRAIGHT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_DY,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIST,
        OP_PCO_INIT,
        OP_CORD_STEP,
        OP_PCL_INIT,
        OP_LCO,
        OP_LEN_MUL,
        OP_LEN,
        OP_COMMIT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic has_point;
        logic last_point;
        logic v_zero;
        logic w_zero;
        logic r_zero;
        logic at_centre;
        logic dist_far;
        logic out_free;
    } t_status;

    // atan(2^-i) in q16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [CORD_IDX_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            4'd0:    a = 20'sd51472;
            4'd1:    a = 20'sd30386;
            4'd2:    a = 20'sd16055;
            4'd3:    a = 20'sd8150;
            4'd4:    a = 20'sd4091;
            4'd5:    a = 20'sd2047;
            4'd6:    a = 20'sd1024;
            4'd7:    a = 20'sd512;
            4'd8:    a = 20'sd256;
            4'd9:    a = 20'sd128;
            4'd10:   a = 20'sd64;
            4'd11:   a = 20'sd32;
            4'd12:   a = 20'sd16;
            4'd13:   a = 20'sd8;
            4'd14:   a = 20'sd4;
            4'd15:   a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/arc_free_path_length.sv */
// ----------------------------------------------------------------------------
// arc_free_path_length
// Shortest free path of a disc along a candidate (v, w) arc over a stream
// of obstacle points.
//
// Input channel: one word per point with the candidate speed pair; a word
// is taken when i_in_valid is high and o_in_stall is low. A word marked
// last point closes the query and one result word follows on the output
// channel (o_out_valid, i_out_stall), held steady while stalled.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// write only while no query word is in flight.
// Sequencing: one word at a time. A word without a point, or with zero speed,
// ends after the check; a straight-line point adds a commit step; a turning
// point runs the 26-step divider and, unless it leaves early, the 28-step
// square root and two 16-step cordic passes that share one shifter. The result
// register separates the output: the next word is accepted while a result waits,
// and only a closing word waits in its final state for the register to free.
// Reset: synchronous, active low; clears the running minimum, the result valid
// flag and the sequencer, and loads the default register values.
// ----------------------------------------------------------------------------
module arc_free_path_length
    import afpl_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [SPEED_W-1:0]     i_forward_speed,
    input  logic signed [SPEED_W-1:0]     i_turn_rate,
    input  logic                          i_has_point,
    input  logic                          i_last_point,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_blocked,
    output logic                          o_obstacle_seen,
    output logic signed [LEN_W-1:0]       o_free_path_length,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CLR_W-1:0]              i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    afpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    afpl_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_forward_speed    (i_forward_speed),
        .i_turn_rate        (i_turn_rate),
        .i_has_point        (i_has_point),
        .i_last_point       (i_last_point),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_blocked          (o_blocked),
        .o_obstacle_seen    (o_obstacle_seen),
        .o_free_path_length (o_free_path_length)
    );

endmodule

/* rtl/afpl_ctrl.sv */
// ----------------------------------------------------------------------------
// afpl_ctrl
// Sequencer: walks one word through the divide, square root and angle
// steps of the datapath and issues one command per cycle.
// ----------------------------------------------------------------------------
module afpl_ctrl
    import afpl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DIV_DONE,
        S_DY,
        S_GEO,
        S_SQRT_INIT,
        S_SQRT,
        S_DIST,
        S_RANGE,
        S_CORD_PCO,
        S_PCL_INIT,
        S_CORD_PCL,
        S_LCO,
        S_LEN_MUL,
        S_LEN,
        S_COMMIT,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_op              op;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORD_STEPS - 1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.has_point || i_status.v_zero) begin
                    n_state = S_FINISH;
                end else if (i_status.w_zero) begin
                    op      = OP_STRAIGHT;
                    n_state = S_COMMIT;
                end else begin
                    op      = OP_DIV_INIT;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                op    = OP_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIV_DONE;
                end
            end
            S_DIV_DONE: begin
                op      = OP_DIV_DONE;
                n_state = S_DY;
            end
            S_DY: begin
                op      = OP_DY;
                n_state = S_GEO;
            end
            S_GEO: begin
                // degenerate radius or point at the turn centre never hits
                if (i_status.r_zero || i_status.at_centre) begin
                    n_state = S_FINISH;
                end else begin
                    op      = OP_SQ;
                    n_state = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT: begin
                op      = OP_SQRT_INIT;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                op    = OP_SQRT_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                op      = OP_DIST;
                n_state = S_RANGE;
            end
            S_RANGE: begin
                if (i_status.dist_far) begin
                    n_state = S_FINISH;
                end else begin
                    op      = OP_PCO_INIT;
                    n_cnt   = '0;
                    n_state = S_CORD_PCO;
                end
            end
            S_CORD_PCO: begin
                op    = OP_CORD_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_PCL_INIT;
                end
            end
            S_PCL_INIT: begin
                op      = OP_PCL_INIT;
                n_cnt   = '0;
                n_state = S_CORD_PCL;
            end
            S_CORD_PCL: begin
                op    = OP_CORD_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_LCO;
                end
            end
            S_LCO: begin
                op      = OP_LCO;
                n_state = S_LEN_MUL;
            end
            S_LEN_MUL: begin
                op      = OP_LEN_MUL;
                n_state = S_LEN;
            end
            S_LEN: begin
                op      = OP_LEN;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                op      = OP_COMMIT;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_status.last_point) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    op      = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.op   = op;
    assign o_cmd.step = r_cnt;

endmodule

/* rtl/afpl_dp.sv */
// ----------------------------------------------------------------------------
// afpl_dp
// Datapath: word registers, shared divider, square root and cordic steps,
// running minimum and result register.
// ----------------------------------------------------------------------------
module afpl_dp
    import afpl_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [SPEED_W-1:0]     i_forward_speed,
    input  logic signed [SPEED_W-1:0]     i_turn_rate,
    input  logic                          i_has_point,
    input  logic                          i_last_point,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CLR_W-1:0]              i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_blocked,
    output logic                          o_obstacle_seen,
    output logic signed [LEN_W-1:0]       o_free_path_length
);

    logic [RAD_W-1:0] r_rad;
    logic [CLR_W-1:0] r_clr;

    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic signed [SPEED_W-1:0]     r_v, r_w;
    logic                          r_has, r_last;

    logic [REM_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic signed [CY_W-1:0]  r_cy;
    logic [QUO_W-1:0]        r_r;
    logic signed [DY_W-1:0]  r_dy;
    logic [SQ_W-1:0]         r_sqx, r_sqy, r_n, r_res;
    logic [DIST_W-1:0]       r_dist;
    logic signed [CORD_W-1:0] r_cx, r_cyy;
    logic signed [ANG_W-1:0] r_z, r_pco;
    logic [LCO_W-1:0]        r_lco;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_hit;
    logic signed [LEN_W-1:0] r_len, r_best;
    logic                    r_any;

    logic                    r_out_valid;
    logic                    r_blocked, r_seen;
    logic signed [LEN_W-1:0] r_out_len;

    // combinational helpers
    logic [SPEED_W-1:0]        v_mag, w_mag;
    logic [COORD_WIDTH-1:0]    px_mag, py_mag;
    logic [REM_W-1:0]          rem_sh, rem_sub;
    logic signed [DY_W-1:0]    px_ext, py_ext, cy_ext, b_val;
    logic [MAG_W-1:0]          dy_mag;
    logic [2*COORD_WIDTH-1:0]  sq_px;
    logic [2*MAG_W-1:0]        sq_dy;
    logic [CNT_W-1:0]          root_k;
    logic [SQ_W-1:0]           sq_bit, sq_trial;
    logic signed [DIST_W:0]    dist_diff;
    logic signed [CORD_W-1:0]  b_ext, a_ext, c_dx, c_dy;
    logic [CORD_IDX_W-1:0]     c_idx;
    logic signed [ANG_W:0]     ang_diff;
    logic [RND_W-1:0]          rnd;
    logic [RND_W-1:0]          rnd_sh;
    logic signed [31:0]        s_diff;
    logic                      straight_hit;
    logic                      out_free;

    assign v_mag  = r_v[SPEED_W-1] ? SPEED_W'(-r_v) : SPEED_W'(r_v);
    assign w_mag  = r_w[SPEED_W-1] ? SPEED_W'(-r_w) : SPEED_W'(r_w);
    assign px_mag = r_px[COORD_WIDTH-1] ? COORD_WIDTH'(-r_px) : COORD_WIDTH'(r_px);
    assign py_mag = r_py[COORD_WIDTH-1] ? COORD_WIDTH'(-r_py) : COORD_WIDTH'(r_py);

    assign rem_sh  = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
    assign rem_sub = rem_sh - {1'b0, w_mag};

    assign px_ext = {{(DY_W-COORD_WIDTH){r_px[COORD_WIDTH-1]}}, r_px};
    assign py_ext = {{(DY_W-COORD_WIDTH){r_py[COORD_WIDTH-1]}}, r_py};
    assign cy_ext = {r_cy[CY_W-1], r_cy};
    assign dy_mag = r_dy[DY_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
    assign sq_px  = px_mag * px_mag;
    assign sq_dy  = dy_mag * dy_mag;

    assign root_k   = CNT_W'(ROOT_STEPS - 1) - i_cmd.step;
    assign sq_bit   = SQ_W'(1) << {root_k, 1'b0};
    assign sq_trial = r_res + sq_bit;

    assign dist_diff = $signed({2'b00, r_res[ROOT_W-1:0]})
                     - $signed({{(DIST_W+1-QUO_W){1'b0}}, r_r});

    // angle of p - c against -c: x operand flips with the side of the centre
    assign b_val = (r_cy > 0) ? -r_dy : r_dy;
    assign b_ext = {{(CORD_W-DY_W){b_val[DY_W-1]}}, b_val} <<< ANG_SHIFT;
    assign a_ext = $signed({{(CORD_W-COORD_WIDTH){1'b0}}, px_mag}) <<< ANG_SHIFT;

    assign c_idx = i_cmd.step[CORD_IDX_W-1:0];
    assign c_dx  = r_cyy >>> c_idx;
    assign c_dy  = r_cx >>> c_idx;

    assign ang_diff = {r_pco[ANG_W-1], r_pco} - {r_z[ANG_W-1], r_z};

    assign rnd    = {1'b0, r_prod} + RND_W'(32768);
    assign rnd_sh = rnd >> ANG_SHIFT;

    assign s_diff = 32'(signed'(r_px)) - $signed({20'd0, r_rad});
    assign straight_hit = ({{(32-COORD_WIDTH){1'b0}}, py_mag} <= {20'd0, r_rad})
                       && (r_px[COORD_WIDTH-1] == r_v[SPEED_W-1]);

    assign out_free = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= RAD_W'(205);
            r_clr <= CLR_W'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROBOT_RADIUS:    r_rad <= i_cfg_data[RAD_W-1:0];
                CFG_CLEARANCE_LIMIT: r_clr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_px   <= i_point_x;
                r_py   <= i_point_y;
                r_v    <= i_forward_speed;
                r_w    <= i_turn_rate;
                r_has  <= i_has_point;
                r_last <= i_last_point;
                r_hit  <= 1'b0;
            end
            OP_STRAIGHT: begin
                r_hit <= straight_hit;
                if (s_diff > 32'(LEN_MAX)) begin
                    r_len <= LEN_MAX;
                end else if (s_diff < 32'(LEN_MIN)) begin
                    r_len <= LEN_MIN;
                end else begin
                    r_len <= s_diff[LEN_W-1:0];
                end
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= {v_mag, {FRAC_SH{1'b0}}};
            end
            OP_DIV_STEP: begin
                if (rem_sh >= {1'b0, w_mag}) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
            end
            OP_DIV_DONE: begin
                r_r <= r_quo;
                if (r_v[SPEED_W-1] ^ r_w[SPEED_W-1]) begin
                    r_cy <= -$signed({1'b0, r_quo});
                end else begin
                    r_cy <= $signed({1'b0, r_quo});
                end
            end
            OP_DY: begin
                r_dy <= py_ext - cy_ext;
            end
            OP_SQ: begin
                r_sqx <= {{(SQ_W-2*COORD_WIDTH){1'b0}}, sq_px};
                r_sqy <= {{(SQ_W-2*MAG_W){1'b0}}, sq_dy};
            end
            OP_SQRT_INIT: begin
                r_n   <= r_sqx + r_sqy;
                r_res <= '0;
            end
            OP_SQRT_STEP: begin
                if (r_n >= sq_trial) begin
                    r_n   <= r_n - sq_trial;
                    r_res <= (r_res >> 1) + sq_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            OP_DIST: begin
                r_dist <= dist_diff[DIST_W] ? DIST_W'(-dist_diff) : DIST_W'(dist_diff);
            end
            OP_PCO_INIT: begin
                if (b_val[DY_W-1]) begin
                    r_cx  <= a_ext;
                    r_cyy <= -b_ext;
                    r_z   <= HALF_PI_Q16;
                end else begin
                    r_cx  <= b_ext;
                    r_cyy <= a_ext;
                    r_z   <= '0;
                end
            end
            OP_PCL_INIT: begin
                r_pco <= r_z;
                r_cx  <= $signed({{(CORD_W-QUO_W){1'b0}}, r_r}) <<< ANG_SHIFT;
                r_cyy <= $signed({{(CORD_W-RAD_W){1'b0}}, r_rad}) <<< ANG_SHIFT;
                r_z   <= '0;
            end
            OP_CORD_STEP: begin
                if (!r_cyy[CORD_W-1]) begin
                    r_cx  <= r_cx + c_dx;
                    r_cyy <= r_cyy - c_dy;
                    r_z   <= r_z + atan_q16(c_idx);
                end else begin
                    r_cx  <= r_cx - c_dx;
                    r_cyy <= r_cyy + c_dy;
                    r_z   <= r_z - atan_q16(c_idx);
                end
            end
            OP_LCO: begin
                r_lco <= ang_diff[ANG_W] ? LCO_W'(-ang_diff) : LCO_W'(ang_diff);
            end
            OP_LEN_MUL: begin
                r_prod <= r_lco * r_r;
            end
            OP_LEN: begin
                r_hit <= 1'b1;
                if (rnd_sh > RND_W'(LEN_MAX)) begin
                    r_len <= LEN_MAX;
                end else begin
                    r_len <= rnd_sh[LEN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // running minimum and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_COMMIT && r_hit) begin
                if (!r_any || r_len < r_best) begin
                    r_best <= r_len;
                end
                r_any <= 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_blocked   <= r_any && (r_best <= $signed({{(LEN_W-CLR_W){1'b0}}, r_clr}));
                r_seen      <= r_any;
                r_out_len   <= r_any ? r_best : '0;
                r_best      <= '0;
                r_any       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.has_point  = r_has;
    assign o_status.last_point = r_last;
    assign o_status.v_zero     = (r_v == '0);
    assign o_status.w_zero     = (r_w == '0);
    assign o_status.r_zero     = (r_r == '0);
    assign o_status.at_centre  = (r_px == '0) && (r_dy == '0);
    assign o_status.dist_far   = (r_dist >= {{(DIST_W-RAD_W){1'b0}}, r_rad});
    assign o_status.out_free   = out_free;

    assign o_out_valid        = r_out_valid;
    assign o_blocked          = r_blocked;
    assign o_obstacle_seen    = r_seen;
    assign o_free_path_length = r_out_len;

endmodule

/* test/arc_free_path_length_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_free_path_length_tb
// Streams obstacle points and speed pairs into the free path length unit,
// predicts each query result in the bench and compares it field by field,
// across several radius and clearance settings with random idling on both
// sides.
// ----------------------------------------------------------------------------
module arc_free_path_length_tb;
    import afpl_pkg::*;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [SPEED_W-1:0]     v;
        logic signed [SPEED_W-1:0]     w;
        logic                          has_pt;
        logic                          last_pt;
    } t_point_word;

    typedef struct packed {
        logic                    blocked;
        logic                    seen;
        logic signed [LEN_W-1:0] len;
    } t_path_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [COORD_WIDTH-1:0] i_point_x = '0;
    logic signed [COORD_WIDTH-1:0] i_point_y = '0;
    logic signed [SPEED_W-1:0] i_forward_speed = '0;
    logic signed [SPEED_W-1:0] i_turn_rate = '0;
    logic i_has_point = 1'b0;
    logic i_last_point = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_blocked;
    logic o_obstacle_seen;
    logic signed [LEN_W-1:0] o_free_path_length;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CLR_W-1:0] i_cfg_data = '0;

    arc_free_path_length uut (.*);

    always #4 i_clk = ~i_clk;

    // bench copy of configuration and running minimum
    longint radius_cfg = 205;
    longint clear_cfg = 1024;
    longint min_len = 0;
    bit hit_seen = 0;

    t_point_word pending_words[$];
    t_path_result expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int words_sent = 0;
    longint cycle_count = 0;
    bit idle_enable = 1;
    bit rx_hold = 0;
    bit tx_pause = 0;

    function automatic longint shift_right(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - res - bitv;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // cordic vectoring angle of (x, y), y >= 0, q16 radians
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Q16;
        end
        for (int i = 0; i < CORD_STEPS; i++) begin
            dx = shift_right(y, i);
            dy = shift_right(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q16(CORD_IDX_W'(i));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q16(CORD_IDX_W'(i));
            end
        end
        return z;
    endfunction

    function automatic bit path_hit(longint px, longint py, longint v, longint w,
                                    output longint len);
        longint cy, r, dy, ring_gap, a, b, lco, prod;
        len = 0;
        if (v == 0) return 0;
        if (w == 0) begin
            if ((py < 0 ? -py : py) <= radius_cfg && ((px >= 0) == (v > 0))) begin
                len = px - radius_cfg;
                return 1;
            end
            return 0;
        end
        cy = (v * 1024) / w;
        r = cy < 0 ? -cy : cy;
        dy = py - cy;
        if (r == 0) return 0;
        if (px == 0 && dy == 0) return 0;
        ring_gap = int_sqrt(px * px + dy * dy) - r;
        if (ring_gap < 0) ring_gap = -ring_gap;
        if (ring_gap >= radius_cfg) return 0;
        a = px < 0 ? -px : px;
        b = cy > 0 ? -dy : dy;
        lco = vector_angle(a, b) - vector_angle(radius_cfg, r);
        if (lco < 0) lco = -lco;
        prod = (lco * r + 32768) >>> 16;
        len = prod > LEN_MAX ? longint'(LEN_MAX) : prod;
        return 1;
    endfunction

    task automatic predict_word(input t_point_word wd);
        longint len;
        t_path_result res;
        if (wd.has_pt && path_hit(wd.px, wd.py, wd.v, wd.w, len)) begin
            if (!hit_seen || len < min_len) min_len = len;
            hit_seen = 1;
        end
        if (wd.last_pt) begin
            res.blocked = hit_seen && min_len <= clear_cfg;
            res.seen = hit_seen;
            res.len = hit_seen ? min_len[LEN_W-1:0] : '0;
            expected_results = {expected_results, res};
            min_len = 0;
            hit_seen = 0;
        end
    endtask

    // driver: prediction happens at acceptance
    int tx_gap = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_word({i_point_x, i_point_y, i_forward_speed, i_turn_rate,
                              i_has_point, i_last_point});
                words_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (tx_pause || pending_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 15) == 0) begin
                    tx_gap <= $urandom_range(1, 19) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    t_point_word wd;
                    wd = pending_words.pop_front();
                    i_point_x <= wd.px;
                    i_point_y <= wd.py;
                    i_forward_speed <= wd.v;
                    i_turn_rate <= wd.w;
                    i_has_point <= wd.has_pt;
                    i_last_point <= wd.last_pt;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and output stall
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word");
                end else begin
                    t_path_result e;
                    e = expected_results.pop_front();
                    if (e.blocked !== o_blocked || e.seen !== o_obstacle_seen ||
                        e.len !== o_free_path_length) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp b=%0b s=%0b len=%0d got b=%0b s=%0b len=%0d",
                                     e.blocked, e.seen, e.len, o_blocked,
                                     o_obstacle_seen, o_free_path_length);
                    end
                end
            end
            if (rx_hold) begin
                i_out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_stall <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 12) == 0) begin
                rx_gap <= $urandom_range(1, 19) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 3000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val[CLR_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROBOT_RADIUS) radius_cfg = val & 12'hFFF;
        else clear_cfg = val & 16'hFFFF;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_WIDTH'($urandom);
            1: return COORD_WIDTH'($urandom_range(0, 8191) - 4096);
            2: return COORD_WIDTH'($urandom_range(0, 600) - 300);
            default: return COORD_WIDTH'($urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    function automatic t_point_word make_word(logic signed [SPEED_W-1:0] v,
                                              logic signed [SPEED_W-1:0] w,
                                              bit last_pt);
        t_point_word wd;
        wd.px = pick_coord();
        wd.py = pick_coord();
        wd.v = v;
        wd.w = w;
        wd.has_pt = $urandom_range(0, 9) != 0;
        wd.last_pt = last_pt;
        return wd;
    endfunction

    // one query of random length sharing one speed pair, sometimes plus a non-closing word
    task automatic add_query();
        logic signed [SPEED_W-1:0] v, w;
        int n;
        case ($urandom_range(0, 5))
            0: v = SPEED_W'($urandom);
            1: v = '0;
            default: v = SPEED_W'($urandom_range(0, 4000) - 2000);
        endcase
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = SPEED_W'($urandom);
            default: w = SPEED_W'($urandom_range(0, 4000) - 2000);
        endcase
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            pending_words = {pending_words, make_word(v, w, i == n - 1)};
        if ($urandom_range(0, 9) == 0)
            pending_words = {pending_words, make_word(v, w, 0)};
    endtask

    task automatic add_fixed(int px, int py, int v, int w, bit hp, bit lp);
        t_point_word wd;
        wd.px = COORD_WIDTH'(px); wd.py = COORD_WIDTH'(py);
        wd.v = SPEED_W'(v); wd.w = SPEED_W'(w);
        wd.has_pt = hp; wd.last_pt = lp;
        pending_words = {pending_words, wd};
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: straight, turning, zero speed, centre, degenerate radius, extremes
        add_fixed(2000, 100, 500, 0, 1, 1);
        add_fixed(-2000, -100, -500, 0, 1, 1);
        add_fixed(32767, 0, 32767, 0, 1, 0);
        add_fixed(-32768, 0, -32768, 0, 1, 1);
        add_fixed(1000, 0, 0, 100, 1, 1);
        add_fixed(0, 1024, 1024, 1024, 1, 1);
        add_fixed(1000, 100, 1, 32767, 1, 1);
        add_fixed(1000, 1000, 1024, 1024, 1, 1);
        add_fixed(-1000, -1000, 1024, -1024, 1, 1);
        add_fixed(-32768, 32767, 32767, -32768, 1, 1);
        add_fixed(32767, -32768, -32768, 32767, 1, 1);
        add_fixed(500, 0, 1000, 0, 0, 0);
        add_fixed(500, 0, 1000, 0, 0, 1);
        add_fixed(150, 0, 1000, 0, 1, 1);
        add_fixed(1, 1, 1, -1, 1, 1);
        wait_drained();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_ROBOT_RADIUS, 0); write_reg(CFG_CLEARANCE_LIMIT, 0); end
                1: begin write_reg(CFG_ROBOT_RADIUS, 4095); write_reg(CFG_CLEARANCE_LIMIT, 65535); end
                2: begin write_reg(CFG_ROBOT_RADIUS, 205); write_reg(CFG_CLEARANCE_LIMIT, 1024); end
                default: begin
                    write_reg(CFG_ROBOT_RADIUS, $urandom_range(0, 4095));
                    write_reg(CFG_CLEARANCE_LIMIT, $urandom_range(0, 65535));
                end
            endcase
            if (ph == 5) idle_enable = 0;
            while (pending_words.size() < 280) add_query();
            if (ph == 1) begin
                // long output hold while words keep coming
                rx_hold = 1;
                repeat (4000) @(posedge i_clk);
                rx_hold = 0;
            end
            if (ph == 3) begin
                while (pending_words.size() > 140) @(posedge i_clk);
                tx_pause = 1;
                while (i_in_valid || expected_results.size() != 0) @(posedge i_clk);
                tx_pause = 0;
            end
            wait_drained();
        end
        $display("sent %0d point words, checked %0d results over six register settings",
                 words_sent, results_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
